FILE: src/stc_pkg.sv
package stc_pkg;

  // Payload widths of the two channels
  localparam int SRC_W = 64;
  localparam int RES_W = 64;

  // Leading-zero counter geometry
  localparam int MAG_W = 32;
  localparam int CNT_W = 6;

  // Element type codes
  localparam logic [3:0] TYPE_DOUBLE = 4'd0;
  localparam logic [3:0] TYPE_SINGLE = 4'd1;
  localparam logic [3:0] TYPE_S32    = 4'd2;
  localparam logic [3:0] TYPE_S16    = 4'd3;
  localparam logic [3:0] TYPE_S8     = 4'd4;
  localparam logic [3:0] TYPE_U32    = 4'd5;
  localparam logic [3:0] TYPE_U16    = 4'd6;
  localparam logic [3:0] TYPE_U8     = 4'd7;
  localparam logic [3:0] TYPE_BOOL   = 4'd8;

  // Register indexes
  localparam logic CFG_SOURCE_TYPE = 1'b0;
  localparam logic CFG_DEST_TYPE   = 1'b1;

  // Largest finite single, as single bits and as double magnitude bits
  localparam logic [31:0] FLT_MAX_BITS      = 32'h7F7F_FFFF;
  localparam logic [62:0] FLT_MAX_AS_DOUBLE = 63'h47EF_FFFF_E000_0000;

  // Integer limits, 34 bit signed
  localparam logic signed [33:0] LIM_S32_MAX = 34'sd2147483647;
  localparam logic signed [33:0] LIM_S32_MIN = -34'sd2147483648;
  localparam logic signed [33:0] LIM_S16_MAX = 34'sd32767;
  localparam logic signed [33:0] LIM_S16_MIN = -34'sd32768;
  localparam logic signed [33:0] LIM_S8_MAX  = 34'sd127;
  localparam logic signed [33:0] LIM_S8_MIN  = -34'sd128;
  localparam logic signed [33:0] LIM_U32_MAX = 34'sd4294967295;
  localparam logic signed [33:0] LIM_U16_MAX = 34'sd65535;
  localparam logic signed [33:0] LIM_U8_MAX  = 34'sd255;

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_FINITE,
    CLS_INF,
    CLS_NAN
  } cls_e;

endpackage

FILE: src/stc_if.sv
interface stc_in_if import stc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SRC_W-1:0] source_bits;
  modport source(output valid, output source_bits, input ready);
  modport sink(input valid, input source_bits, output ready);
endinterface

interface stc_out_if import stc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] result_bits;
  modport source(output valid, output result_bits, input ready);
  modport sink(input valid, input result_bits, output ready);
endinterface

FILE: src/stc_lzc32.sv
module stc_lzc32 import stc_pkg::*; (
  input  logic [MAG_W-1:0] mag_i,
  output logic [CNT_W-1:0] cnt_o
);

  logic [MAG_W-1:0] v;
  logic [CNT_W-1:0] n;

  // binary search, all-zero gives 32
  always_comb begin
    v = mag_i;
    n = '0;
    if (v[31:16] == 16'd0) begin
      n = n + 6'd16;
      v = v << 16;
    end
    if (v[31:24] == 8'd0) begin
      n = n + 6'd8;
      v = v << 8;
    end
    if (v[31:28] == 4'd0) begin
      n = n + 6'd4;
      v = v << 4;
    end
    if (v[31:30] == 2'd0) begin
      n = n + 6'd2;
      v = v << 2;
    end
    if (!v[31]) begin
      n = n + 6'd1;
      v = v << 1;
    end
    if (!v[31]) begin
      n = n + 6'd1;
    end
    cnt_o = n;
  end

endmodule

FILE: src/saturating_type_cast_top.sv
// Saturating element type converter.
// Converts between double, single, s32/s16/s8, u32/u16/u8 and bool.
// Channels: in_i carries source_bits (value in the low bits of its type),
// out_o carries result_bits (low bits of the destination width, rest zero).
// Both use valid/ready; a transfer happens when both are high at a clock edge.
// Configuration: cfg_we_i with cfg_idx_i (0 source type, 1 dest type) and
// cfg_data_i; write only while no item is in flight.
// Pipeline: four register stages: unpack, normalise (32 bit leading-zero
// count), align and round-bit extraction, then round/saturate/pack.
// Throughput: one item per cycle while out_o accepts.
// Receiver stall: each stage holds while the stage after it is full and cannot
// move on, so the pipe fills up to four items before in_i.ready drops; nothing is lost.
// Reset: empties the pipe and sets both types to double.
// Unknown type codes give a zero result.
module saturating_type_cast_top import stc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [3:0]   cfg_data_i,
  stc_in_if.sink       in_i,
  stc_out_if.source    out_o
);

  // stage 1: unpacked operand
  typedef struct packed {
    logic [63:0] x;
    logic [3:0]  s;
    logic [3:0]  d;
    logic        bad;
    logic        sgn;
    cls_e        cls;
    logic        norm;   // magnitude still needs normalising
    logic [31:0] mag;
    logic [12:0] eb;     // exponent of the magnitude's bit 31
    logic [52:0] m;
    logic [12:0] e;
  } s1_t;

  // stage 2: value = m * 2^(e-52)
  typedef struct packed {
    logic [63:0] x;
    logic [3:0]  s;
    logic [3:0]  d;
    logic        bad;
    logic        sgn;
    cls_e        cls;
    logic [52:0] m;
    logic [12:0] e;
  } s2_t;

  // stage 3: per-destination partial results
  typedef struct packed {
    logic [3:0]  d;
    logic        bad;
    logic        sgn;
    cls_e        cls;
    logic [63:0] dbl;
    logic        sgl_sp;
    logic [31:0] sgl_sp_val;
    logic [30:0] sgl_pre;
    logic        sgl_inc;
    logic [32:0] t;
  } s3_t;

  logic [3:0] src_q, dst_q;
  logic       v1_q, v2_q, v3_q, v4_q;
  logic       rdy1, rdy2, rdy3, rdy4;
  s1_t        a_d, r1_q;
  s2_t        b_d, r2_q;
  s3_t        c_d, r3_q;
  logic [63:0] res_d, res_q;
  logic [3:0]  d4_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= TYPE_DOUBLE;
      dst_q <= TYPE_DOUBLE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SOURCE_TYPE: src_q <= cfg_data_i;
        CFG_DEST_TYPE:   dst_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // flow control: a stage loads when it is empty or its contents move on
  assign rdy4       = !v4_q || out_o.ready;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) r1_q <= a_d;
    if (rdy2) r2_q <= b_d;
    if (rdy3) r3_q <= c_d;
    if (rdy4) begin
      res_q <= res_d;
      d4_q  <= r3_q.d;
    end
  end

  // ---- stage 1: unpack ----
  logic [10:0] dexp;
  logic [51:0] dfrac;
  logic [7:0]  fexp;
  logic [22:0] ffrac;
  logic [31:0] sx;

  always_comb begin
    dexp  = in_i.source_bits[62:52];
    dfrac = in_i.source_bits[51:0];
    fexp  = in_i.source_bits[30:23];
    ffrac = in_i.source_bits[22:0];
    sx    = '0;
    a_d       = '0;
    a_d.x     = in_i.source_bits;
    a_d.s     = src_q;
    a_d.d     = dst_q;
    a_d.bad   = (src_q > TYPE_BOOL) || (dst_q > TYPE_BOOL);
    a_d.cls   = CLS_ZERO;
    a_d.eb    = 13'd31;
    case (src_q)
      TYPE_DOUBLE: begin
        a_d.sgn = in_i.source_bits[63];
        if (dexp == 11'h7FF) begin
          a_d.cls = (dfrac != 52'd0) ? CLS_NAN : CLS_INF;
        end else if (dexp == 11'd0) begin
          a_d.cls = (dfrac != 52'd0) ? CLS_FINITE : CLS_ZERO;
          a_d.m   = {1'b0, dfrac};
          a_d.e   = -13'sd1022;
        end else begin
          a_d.cls = CLS_FINITE;
          a_d.m   = {1'b1, dfrac};
          a_d.e   = {2'b00, dexp} - 13'd1023;
        end
      end
      TYPE_SINGLE: begin
        a_d.sgn = in_i.source_bits[31];
        if (fexp == 8'hFF) begin
          a_d.cls = (ffrac != 23'd0) ? CLS_NAN : CLS_INF;
        end else if (fexp == 8'd0) begin
          // subnormal: normalised next stage, value = frac * 2^-149
          a_d.cls  = (ffrac != 23'd0) ? CLS_FINITE : CLS_ZERO;
          a_d.norm = 1'b1;
          a_d.mag  = {9'd0, ffrac};
          a_d.eb   = -13'sd118;
        end else begin
          a_d.cls = CLS_FINITE;
          a_d.m   = {1'b1, ffrac, 29'd0};
          a_d.e   = {5'd0, fexp} - 13'd127;
        end
      end
      default: begin
        case (src_q)
          TYPE_S32: sx = in_i.source_bits[31:0];
          TYPE_S16: sx = {{16{in_i.source_bits[15]}}, in_i.source_bits[15:0]};
          TYPE_S8:  sx = {{24{in_i.source_bits[7]}}, in_i.source_bits[7:0]};
          TYPE_U32: sx = in_i.source_bits[31:0];
          TYPE_U16: sx = {16'd0, in_i.source_bits[15:0]};
          TYPE_U8:  sx = {24'd0, in_i.source_bits[7:0]};
          TYPE_BOOL: sx = {31'd0, |in_i.source_bits[31:0]};
          default:  sx = '0;
        endcase
        a_d.sgn  = (src_q == TYPE_S32 || src_q == TYPE_S16 || src_q == TYPE_S8)
                   && sx[31];
        a_d.mag  = a_d.sgn ? (~sx + 32'd1) : sx;
        a_d.norm = 1'b1;
        a_d.cls  = (sx != 32'd0) ? CLS_FINITE : CLS_ZERO;
      end
    endcase
  end

  // ---- stage 2: normalise ----
  logic [CNT_W-1:0] lz;
  logic [31:0]      nmag;

  stc_lzc32 u_lzc (
    .mag_i (r1_q.mag),
    .cnt_o (lz)
  );

  assign nmag = r1_q.mag << lz;

  always_comb begin
    b_d.x   = r1_q.x;
    b_d.s   = r1_q.s;
    b_d.d   = r1_q.d;
    b_d.bad = r1_q.bad;
    b_d.sgn = r1_q.sgn;
    b_d.cls = r1_q.cls;
    if (r1_q.norm) begin
      b_d.m = {nmag, 21'd0};
      b_d.e = r1_q.eb - {7'd0, lz};
    end else begin
      b_d.m = r1_q.m;
      b_d.e = r1_q.e;
    end
  end

  // ---- stage 3: align ----
  logic signed [12:0] es, sub_sh;
  logic [5:0]   rs, ish;
  logic         nrm;
  logic [107:0] wide;
  logic [23:0]  q;
  logic [12:0]  e127, e1023, d52;
  logic [52:0]  tsh;
  logic         clamp;
  logic [63:0]  x2;

  always_comb begin
    x2     = r2_q.x;
    es     = $signed(r2_q.e);
    sub_sh = -13'sd97 - es;
    if (es >= -13'sd126) begin
      rs  = 6'd29;
      nrm = 1'b1;
    end else begin
      rs  = (sub_sh > 13'sd55) ? 6'd55 : sub_sh[5:0];
      nrm = 1'b0;
    end
    wide  = {r2_q.m, 55'd0} >> rs;
    q     = wide[78:55];
    e127  = r2_q.e + 13'd127;
    e1023 = r2_q.e + 13'd1023;
    d52   = 13'd52 - r2_q.e;
    ish   = d52[5:0];
    tsh   = r2_q.m >> ish;
    clamp = (r2_q.s == TYPE_DOUBLE) && ((r2_q.cls == CLS_INF) ||
            (r2_q.cls == CLS_FINITE && x2[62:0] >= FLT_MAX_AS_DOUBLE));

    c_d.d       = r2_q.d;
    c_d.bad     = r2_q.bad;
    c_d.sgn     = r2_q.sgn;
    c_d.cls     = r2_q.cls;
    c_d.sgl_pre = {(nrm ? e127[7:0] : 8'd0), q[22:0]};
    c_d.sgl_inc = wide[54] & ((|wide[53:0]) | q[0]);

    // single special values: same type, NaN, clamp, zero
    c_d.sgl_sp     = 1'b1;
    c_d.sgl_sp_val = {r2_q.sgn, 31'd0};
    if (r2_q.s == TYPE_SINGLE) begin
      c_d.sgl_sp_val = x2[31:0];
    end else if (r2_q.cls == CLS_NAN) begin
      c_d.sgl_sp_val = {x2[63], 9'h1FF, x2[50:29]};
    end else if (clamp) begin
      c_d.sgl_sp_val = {r2_q.sgn, FLT_MAX_BITS[30:0]};
    end else if (r2_q.cls == CLS_FINITE) begin
      c_d.sgl_sp = 1'b0;
    end

    // double result
    if (r2_q.s == TYPE_DOUBLE) begin
      c_d.dbl = x2;
    end else begin
      case (r2_q.cls)
        CLS_NAN:    c_d.dbl = {x2[31], 12'hFFF, x2[21:0], 29'd0};
        CLS_INF:    c_d.dbl = {r2_q.sgn, 11'h7FF, 52'd0};
        CLS_FINITE: c_d.dbl = {r2_q.sgn, e1023[10:0], r2_q.m[51:0]};
        default:    c_d.dbl = {r2_q.sgn, 63'd0};
      endcase
    end

    // truncated magnitude, saturated past 33 bits
    case (r2_q.cls)
      CLS_INF: c_d.t = '1;
      CLS_FINITE: begin
        if (es < 13'sd0)       c_d.t = '0;
        else if (es > 13'sd32) c_d.t = '1;
        else                   c_d.t = tsh[32:0];
      end
      default: c_d.t = '0;
    endcase
  end

  // ---- stage 4: round, saturate, pack ----
  logic [30:0]        smag;
  logic [33:0]        n;
  logic signed [33:0] lo, hi, nc;

  always_comb begin
    smag = r3_q.sgl_pre + {30'd0, r3_q.sgl_inc};
    n    = r3_q.sgn ? (~{1'b0, r3_q.t} + 34'd1) : {1'b0, r3_q.t};
    case (r3_q.d)
      TYPE_S32: begin lo = LIM_S32_MIN; hi = LIM_S32_MAX; end
      TYPE_S16: begin lo = LIM_S16_MIN; hi = LIM_S16_MAX; end
      TYPE_S8:  begin lo = LIM_S8_MIN;  hi = LIM_S8_MAX;  end
      TYPE_U32: begin lo = '0;          hi = LIM_U32_MAX; end
      TYPE_U16: begin lo = '0;          hi = LIM_U16_MAX; end
      default:  begin lo = '0;          hi = LIM_U8_MAX;  end
    endcase
    if ($signed(n) > hi)      nc = hi;
    else if ($signed(n) < lo) nc = lo;
    else                      nc = $signed(n);
    if (r3_q.cls == CLS_NAN) nc = '0;

    case (r3_q.d)
      TYPE_DOUBLE: res_d = r3_q.dbl;
      TYPE_SINGLE: res_d = {32'd0, (r3_q.sgl_sp ? r3_q.sgl_sp_val : {r3_q.sgn, smag})};
      TYPE_BOOL:   res_d = {63'd0, (r3_q.cls == CLS_FINITE || r3_q.cls == CLS_INF)};
      TYPE_S32,
      TYPE_U32:    res_d = {32'd0, nc[31:0]};
      TYPE_S16,
      TYPE_U16:    res_d = {48'd0, nc[15:0]};
      TYPE_S8,
      TYPE_U8:     res_d = {56'd0, nc[7:0]};
      default:     res_d = '0;
    endcase
    if (r3_q.bad) res_d = '0;
  end

  assign out_o.valid       = v4_q;
  assign out_o.result_bits = res_q;

  // ---- assertions ----
  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && v3_q && v4_q))
    else $error("input stalled with a bubble in the pipe");

  a_fill_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !v4_q) |=> v4_q)
    else $error("empty output stage not refilled");

  a_bool_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && d4_q == TYPE_BOOL) |-> (out_o.result_bits[63:1] == 63'd0))
    else $error("bool result not 0 or 1");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && d4_q > TYPE_BOOL) |-> (out_o.result_bits == 64'd0))
    else $error("unknown destination gave non-zero result");

endmodule
